// ===== rtl/fpd_pkg.sv =====
// Shared types and constants for the flight phase detector.
// No dependencies; imported by every module of the block.
package fpd_pkg;

    localparam int unsigned TimeW   = 32;
    localparam int unsigned AccelW  = 16;
    localparam int unsigned AltW    = 32;
    localparam int unsigned HoldW   = 16;
    localparam int unsigned MagW    = 32;
    localparam int unsigned SqW     = 31;  // a 16 bit square reaches 2^30 at -32768
    localparam int unsigned CfgIdxW = 8;
    localparam int unsigned CfgDatW = 32;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_LAUNCH_THR  = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CFG_LAUNCH_HOLD = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] CFG_COAST_HOLD  = CfgIdxW'(2);
    localparam logic [CfgIdxW-1:0] CFG_APOGEE_HOLD = CfgIdxW'(3);

    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_BOOST  = 2'd1,
        PH_COAST  = 2'd2,
        PH_APOGEE = 2'd3
    } t_phase;

    typedef struct packed {
        logic [MagW-1:0]  launch_thr;
        logic [HoldW-1:0] launch_hold;
        logic [HoldW-1:0] coast_hold;
        logic [HoldW-1:0] apogee_hold;
    } t_cfg;

endpackage

// ===== rtl/flight_phase_detector_top.sv =====
// Top level of the flight phase detector: config registers, sample pipeline
// and handshake. Depends on fpd_pkg, fpd_mag, fpd_phase.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------
//  sample   | i_in_valid / o_in_ready      | i_sample_time, i_accel_*, i_altitude_cm
//  result   | o_out_valid / i_out_ready    | o_phase, o_phase_changed, o_liftoff_time
//  config   | i_cfg_we                     | i_cfg_index, i_cfg_wdata
//
// Three register stages: input capture, per-axis squares, then sum, compare and
// phase update into the result register. One beat per cycle sustained. The squares
// multipliers set the stage split. Each stage moves when the one after it is empty or
// moving, so a held result stalls intake only once all three stages are full.
// Synchronous reset clears phase state, valids and config.
module flight_phase_detector_top
    import fpd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CfgIdxW-1:0]       i_cfg_index,
    input  logic [CfgDatW-1:0]       i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [TimeW-1:0]         i_sample_time,
    input  logic signed [AccelW-1:0] i_accel_x,
    input  logic signed [AccelW-1:0] i_accel_y,
    input  logic signed [AccelW-1:0] i_accel_z,
    input  logic signed [AltW-1:0]   i_altitude_cm,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [1:0]               o_phase,
    output logic                     o_phase_changed,
    output logic [TimeW-1:0]         o_liftoff_time
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LAUNCH_THR:  r_cfg.launch_thr  <= i_cfg_wdata[MagW-1:0];
                CFG_LAUNCH_HOLD: r_cfg.launch_hold <= i_cfg_wdata[HoldW-1:0];
                CFG_COAST_HOLD:  r_cfg.coast_hold  <= i_cfg_wdata[HoldW-1:0];
                CFG_APOGEE_HOLD: r_cfg.apogee_hold <= i_cfg_wdata[HoldW-1:0];
                default: ;
            endcase
        end
    end

    logic r_v1, r_v2, r_ov;
    logic w_rdy1, w_rdy2, w_rdy3;

    assign w_rdy3     = !r_ov || i_out_ready;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_ready = w_rdy1;

    // stage 1: captured sample
    logic [TimeW-1:0]         r_t1;
    logic signed [AccelW-1:0] r_ax1, r_ay1, r_az1;
    logic signed [AltW-1:0]   r_alt1;
    // stage 2: fields riding alongside the squares
    logic [TimeW-1:0]         r_t2;
    logic signed [AccelW-1:0] r_az2;
    logic signed [AltW-1:0]   r_alt2;

    logic w_load2, w_step;
    logic [MagW-1:0] w_mag;

    assign w_load2 = r_v1 && w_rdy2;
    assign w_step  = r_v2 && w_rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_rdy1) begin
            r_t1   <= i_sample_time;
            r_ax1  <= i_accel_x;
            r_ay1  <= i_accel_y;
            r_az1  <= i_accel_z;
            r_alt1 <= i_altitude_cm;
        end
        if (w_load2) begin
            r_t2   <= r_t1;
            r_az2  <= r_az1;
            r_alt2 <= r_alt1;
        end
    end

    fpd_mag u_mag (
        .i_clk  (i_clk),
        .i_load (w_load2),
        .i_ax   (r_ax1),
        .i_ay   (r_ay1),
        .i_az   (r_az1),
        .o_mag  (w_mag)
    );

    fpd_phase u_phase (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_cfg     (r_cfg),
        .i_time    (r_t2),
        .i_az      (r_az2),
        .i_alt     (r_alt2),
        .i_mag     (w_mag),
        .o_phase   (o_phase),
        .o_changed (o_phase_changed),
        .o_liftoff (o_liftoff_time)
    );

    assign o_out_valid = r_ov;

endmodule

// ===== rtl/fpd_mag.sv =====
// Squared acceleration magnitude: registered per-axis squares, then the sum.
// Depends on fpd_pkg.
module fpd_mag
    import fpd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_load,
    input  logic signed [AccelW-1:0] i_ax,
    input  logic signed [AccelW-1:0] i_ay,
    input  logic signed [AccelW-1:0] i_az,
    output logic [MagW-1:0]          o_mag
);

    logic signed [31:0] w_px, w_py, w_pz;
    logic [SqW-1:0]     r_sx, r_sy, r_sz;

    assign w_px = 32'(i_ax) * 32'(i_ax);
    assign w_py = 32'(i_ay) * 32'(i_ay);
    assign w_pz = 32'(i_az) * 32'(i_az);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sx <= w_px[SqW-1:0];
            r_sy <= w_py[SqW-1:0];
            r_sz <= w_pz[SqW-1:0];
        end
    end

    // max 3 * 2^30, fits 32 bits
    assign o_mag = MagW'(r_sx) + MagW'(r_sy) + MagW'(r_sz);

endmodule

// ===== rtl/fpd_phase.sv =====
// Flight phase state machine with hold-time watch, running max altitude
// and the registered result fields. Depends on fpd_pkg.
module fpd_phase
    import fpd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  t_cfg                   i_cfg,
    input  logic [TimeW-1:0]       i_time,
    input  logic signed [AccelW-1:0] i_az,
    input  logic signed [AltW-1:0] i_alt,
    input  logic [MagW-1:0]        i_mag,
    output logic [1:0]             o_phase,
    output logic                   o_changed,
    output logic [TimeW-1:0]       o_liftoff
);

    t_phase                 r_phase, n_phase;
    logic                   r_armed, n_armed;
    logic [TimeW-1:0]       r_start, n_start;
    logic signed [AltW-1:0] r_high, n_high;
    logic [TimeW-1:0]       r_stamp, n_stamp;
    logic                   r_changed, n_changed;

    logic             w_cond;
    logic [HoldW-1:0] w_hold;
    logic [TimeW-1:0] w_elapsed;
    logic             w_fire;

    always_comb begin
        w_cond = 1'b0;
        w_hold = '0;
        unique case (r_phase)
            PH_WAIT: begin
                w_cond = i_mag > i_cfg.launch_thr;
                w_hold = i_cfg.launch_hold;
            end
            PH_BOOST: begin
                w_cond = i_az < 0;
                w_hold = i_cfg.coast_hold;
            end
            PH_COAST: begin
                w_cond = i_alt < r_high;
                w_hold = i_cfg.apogee_hold;
            end
            PH_APOGEE: begin
                w_cond = 1'b0;
                w_hold = '0;
            end
            default: begin
                w_cond = 1'b0;
                w_hold = '0;
            end
        endcase
    end

    assign w_elapsed = i_time - r_start;
    assign w_fire    = (r_phase != PH_APOGEE) && r_armed && w_cond
                       && (w_elapsed > TimeW'(w_hold));

    // next state
    always_comb begin
        n_phase = r_phase;
        n_armed = r_armed;
        n_start = r_start;
        if (r_phase != PH_APOGEE) begin
            if (r_armed) begin
                if (!w_cond || w_fire) begin
                    n_armed = 1'b0;
                    n_start = '0;
                end
            end else if (w_cond) begin
                n_armed = 1'b1;
                n_start = i_time;
            end
            if (w_fire) begin
                unique case (r_phase)
                    PH_WAIT:  n_phase = PH_BOOST;
                    PH_BOOST: n_phase = PH_COAST;
                    PH_COAST: n_phase = PH_APOGEE;
                    default:  n_phase = r_phase;
                endcase
            end
        end
        n_high = (i_alt > r_high) ? i_alt : r_high;
    end

    // result fields
    always_comb begin
        n_changed = w_fire;
        n_stamp   = (w_fire && r_phase == PH_WAIT) ? i_time : r_stamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_WAIT;
            r_armed   <= 1'b0;
            r_start   <= '0;
            r_high    <= {1'b1, {(AltW-1){1'b0}}};
            r_stamp   <= '0;
            r_changed <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_armed   <= n_armed;
            r_start   <= n_start;
            r_high    <= n_high;
            r_stamp   <= n_stamp;
            r_changed <= n_changed;
        end
    end

    assign o_phase   = r_phase;
    assign o_changed = r_changed;
    assign o_liftoff = r_stamp;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for flight_phase_detector_top: flies one scripted mission from the ground
// through boost, coast and apogee and checks every result beat against a local predictor.
// Depends on fpd_pkg and the RTL under rtl/.
module tb_top;
    import fpd_pkg::*;

    localparam logic [MagW-1:0] MAX_MAG_SQ = 32'd3221225472;
    localparam int unsigned GAP_PCT = 36;
    // indexes past the register file; writes there must be dropped
    localparam logic [CfgIdxW-1:0] CFG_UNUSED_4   = CfgIdxW'(4);
    localparam logic [CfgIdxW-1:0] CFG_UNUSED_5   = CfgIdxW'(5);
    localparam logic [CfgIdxW-1:0] CFG_UNUSED_TOP = CfgIdxW'(255);

    typedef struct {
        logic [TimeW-1:0]         stamp;
        logic signed [AccelW-1:0] ax;
        logic signed [AccelW-1:0] ay;
        logic signed [AccelW-1:0] az;
        logic signed [AltW-1:0]   alt;
    } t_imu_sample;

    typedef struct {
        t_phase           phase;
        logic             changed;
        logic [TimeW-1:0] liftoff;
    } t_phase_report;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CfgIdxW-1:0]       i_cfg_index;
    logic [CfgDatW-1:0]       i_cfg_wdata;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [TimeW-1:0]         i_sample_time;
    logic signed [AccelW-1:0] i_accel_x;
    logic signed [AccelW-1:0] i_accel_y;
    logic signed [AccelW-1:0] i_accel_z;
    logic signed [AltW-1:0]   i_altitude_cm;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [1:0]               o_phase;
    logic                     o_phase_changed;
    logic [TimeW-1:0]         o_liftoff_time;

    flight_phase_detector_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_sample_time   (i_sample_time),
        .i_accel_x       (i_accel_x),
        .i_accel_y       (i_accel_y),
        .i_accel_z       (i_accel_z),
        .i_altitude_cm   (i_altitude_cm),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_phase         (o_phase),
        .o_phase_changed (o_phase_changed),
        .o_liftoff_time  (o_liftoff_time)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    t_cfg                   cfg_shadow;
    t_phase                 fl_phase;
    logic                   watch_on;
    logic [TimeW-1:0]       watch_t0;
    logic signed [AltW-1:0] peak_alt;
    logic [TimeW-1:0]       launch_t;

    t_phase_report    expected_reports[$];
    int               error_count = 0;
    logic             calm = 1'b0;
    logic [TimeW-1:0] now_ms;

    // condition watch shared by all three phases; returns 1 when the hold is met
    function automatic logic watch_hold(input logic cond, input logic [TimeW-1:0] now,
                                        input logic [HoldW-1:0] hold);
        logic [TimeW-1:0] elapsed;
        logic             fired;
        elapsed = now - watch_t0;
        fired = 1'b0;
        if (watch_on) begin
            if (!cond) begin
                watch_on = 1'b0;
                watch_t0 = '0;
            end else if (elapsed > TimeW'(hold)) begin
                watch_on = 1'b0;
                watch_t0 = '0;
                fired = 1'b1;
            end
        end else if (cond) begin
            watch_on = 1'b1;
            watch_t0 = now;
        end
        return fired;
    endfunction

    function automatic t_phase_report advance_flight(input t_imu_sample s);
        longint          sx;
        longint          sy;
        longint          sz;
        logic [MagW-1:0] mag;
        t_phase_report   r;
        sx = s.ax;
        sy = s.ay;
        sz = s.az;
        mag = MagW'(sx * sx + sy * sy + sz * sz);
        r.changed = 1'b0;
        case (fl_phase)
            PH_WAIT: begin
                if (watch_hold(mag > cfg_shadow.launch_thr, s.stamp, cfg_shadow.launch_hold)) begin
                    fl_phase = PH_BOOST;
                    launch_t = s.stamp;
                    r.changed = 1'b1;
                end
            end
            PH_BOOST: begin
                if (watch_hold(s.az < 0, s.stamp, cfg_shadow.coast_hold)) begin
                    fl_phase = PH_COAST;
                    r.changed = 1'b1;
                end
            end
            PH_COAST: begin
                if (watch_hold(s.alt < peak_alt, s.stamp, cfg_shadow.apogee_hold)) begin
                    fl_phase = PH_APOGEE;
                    r.changed = 1'b1;
                end
            end
            default: ;
        endcase
        if (s.alt > peak_alt)
            peak_alt = s.alt;
        r.phase = fl_phase;
        r.liftoff = launch_t;
        return r;
    endfunction

    function automatic t_imu_sample mk(input logic [TimeW-1:0] stamp,
                                       input logic signed [AccelW-1:0] ax,
                                       input logic signed [AccelW-1:0] ay,
                                       input logic signed [AccelW-1:0] az,
                                       input logic signed [AltW-1:0] alt);
        t_imu_sample s;
        s.stamp = stamp;
        s.ax = ax;
        s.ay = ay;
        s.az = az;
        s.alt = alt;
        return s;
    endfunction

    // half full scale, half near zero so the magnitude lands on both sides of mid thresholds
    function automatic logic signed [AccelW-1:0] rand_accel();
        if ($urandom_range(0, 1) != 0)
            return AccelW'($urandom);
        return AccelW'(int'($urandom_range(0, 6000)) - 3000);
    endfunction

    function automatic logic signed [AltW-1:0] rand_alt_low();
        return AltW'(int'($urandom_range(0, 100000)) - 50000);
    endfunction

    function automatic logic [HoldW-1:0] pick_hold();
        case ($urandom_range(0, 2))
            0: return '0;
            1: return '1;
            default: return HoldW'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [MagW-1:0] pick_thr();
        case ($urandom_range(0, 2))
            0: return '0;
            1: return MAX_MAG_SQ;
            default: return $urandom_range(0, MAX_MAG_SQ);
        endcase
    endfunction

    // receiver stalls, except during calm stretches
    always @(posedge i_clk)
        i_out_ready <= calm || ($urandom_range(0, 99) >= GAP_PCT);

    always @(negedge i_clk) begin : check_results
        t_phase_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_reports.size() == 0) begin
                $error("result beat with no sample pending");
                error_count++;
            end else begin
                want = expected_reports.pop_front();
                if (o_phase !== want.phase) begin
                    $error("phase: expected %0d, got %0d", want.phase, o_phase);
                    error_count++;
                end
                if (o_phase_changed !== want.changed) begin
                    $error("phase_changed: expected %0d, got %0d", want.changed,
                           o_phase_changed);
                    error_count++;
                end
                if (o_liftoff_time !== want.liftoff) begin
                    $error("liftoff_time: expected %0h, got %0h", want.liftoff, o_liftoff_time);
                    error_count++;
                end
            end
        end
    end

    task automatic send_sample(input t_imu_sample s);
        if (!calm && $urandom_range(0, 99) < GAP_PCT) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < GAP_PCT);
        end
        i_in_valid    <= 1'b1;
        i_sample_time <= s.stamp;
        i_accel_x     <= s.ax;
        i_accel_y     <= s.ay;
        i_accel_z     <= s.az;
        i_altitude_cm <= s.alt;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        expected_reports.push_back(advance_flight(s));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            CFG_LAUNCH_THR:  cfg_shadow.launch_thr  = data;
            CFG_LAUNCH_HOLD: cfg_shadow.launch_hold = data[HoldW-1:0];
            CFG_COAST_HOLD:  cfg_shadow.coast_hold  = data[HoldW-1:0];
            CFG_APOGEE_HOLD: cfg_shadow.apogee_hold = data[HoldW-1:0];
            default: ;
        endcase
    endtask

    // junk in the upper bits of the hold writes checks the masking
    task automatic load_config(input logic [MagW-1:0] thr, input logic [HoldW-1:0] lh,
                               input logic [HoldW-1:0] ch, input logic [HoldW-1:0] ah);
        drain_results();
        write_reg(CFG_LAUNCH_THR, thr);
        write_reg(CFG_LAUNCH_HOLD, {16'($urandom), lh});
        write_reg(CFG_COAST_HOLD, {16'($urandom), ch});
        write_reg(CFG_APOGEE_HOLD, {16'($urandom), ah});
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_ground_extremes();
        load_config(MAX_MAG_SQ, '1, '1, '1);
        // an aliased decode would zero the threshold and hold and launch at once
        write_reg(CFG_UNUSED_4, '0);
        write_reg(CFG_UNUSED_5, '0);
        write_reg(CFG_UNUSED_TOP, '0);
        i_cfg_we <= 1'b0;
        send_sample(mk('0, 0, 0, 0, 0));
        // largest magnitude equals the threshold: not strictly above, no arm
        send_sample(mk('1, -32768, -32768, -32768, 32'sh8000_0000));
        send_sample(mk(1, 32767, 32767, 32767, -1));
        send_sample(mk(2, -32768, 32767, 0, 12345));
        send_sample(mk(3, 1, -1, -1, -100000));
        send_sample(mk(32'h8000_0000, 21845, -21846, 300, 100000));
    endtask

    // launch hold at max and short steps keep the rocket on the pad
    task automatic test_ground_noise();
        logic [MagW-1:0] thr;
        now_ms = $urandom;
        for (int sub = 0; sub < 4; sub++) begin
            case (sub)
                0: thr = '0;
                1: thr = MAX_MAG_SQ;
                2: thr = $urandom_range(0, MAX_MAG_SQ);
                default: thr = $urandom_range(0, 20_000_000);
            endcase
            load_config(thr, '1, pick_hold(), pick_hold());
            repeat (60) begin
                now_ms += $urandom_range(0, 200);
                send_sample(mk(now_ms, rand_accel(), rand_accel(), rand_accel(), rand_alt_low()));
            end
        end
    endtask

    // watch armed just before the timestamp wraps; the hold is exceeded by one ms after the boundary
    task automatic test_liftoff();
        load_config(32'd1000, 16'd5, '1, '1);
        send_sample(mk(32'hFFFF_FFFC, 0, 0, 0, 0));
        send_sample(mk(32'hFFFF_FFFD, 0, 0, -32768, 10));
        send_sample(mk(32'd2, 100, 0, 0, 20));
        send_sample(mk(32'd3, 0, 40, 0, 30));
        send_sample(mk(32'd4, 0, 0, 0, 40));
        now_ms = 32'd4;
    endtask

    task automatic test_boost_noise();
        for (int sub = 0; sub < 3; sub++) begin
            load_config(pick_thr(), pick_hold(), '1, pick_hold());
            repeat (50) begin
                now_ms += $urandom_range(0, 200);
                send_sample(mk(now_ms, rand_accel(), rand_accel(), rand_accel(), rand_alt_low()));
            end
        end
    endtask

    task automatic test_coast_entry();
        logic [TimeW-1:0] t0;
        load_config(pick_thr(), pick_hold(), 16'd10, '1);
        now_ms += $urandom_range(0, 200);
        send_sample(mk(now_ms, rand_accel(), rand_accel(), 0, rand_alt_low()));
        t0 = now_ms + 1;
        send_sample(mk(t0, rand_accel(), rand_accel(), -1, rand_alt_low()));
        send_sample(mk(t0 + 10, rand_accel(), rand_accel(), -32768, rand_alt_low()));
        send_sample(mk(t0 + 11, rand_accel(), rand_accel(), -5, rand_alt_low()));
        now_ms = t0 + 11;
    endtask

    // altitude wanders around the running peak so the watch keeps toggling
    task automatic test_coast_noise();
        calm = 1'b1;
        for (int sub = 0; sub < 3; sub++) begin
            load_config(pick_thr(), pick_hold(), pick_hold(), '1);
            repeat (50) begin
                now_ms += $urandom_range(0, 200);
                send_sample(mk(now_ms, rand_accel(), rand_accel(), rand_accel(),
                               peak_alt + AltW'(int'($urandom_range(0, 100)) - 50)));
            end
        end
        calm = 1'b0;
    endtask

    // zero hold: same-ms sample does not fire, the next ms does
    task automatic test_apogee_entry();
        load_config(pick_thr(), pick_hold(), pick_hold(), '0);
        now_ms += $urandom_range(0, 50);
        send_sample(mk(now_ms, rand_accel(), rand_accel(), rand_accel(), peak_alt + 1));
        now_ms += $urandom_range(0, 50);
        send_sample(mk(now_ms, rand_accel(), rand_accel(), rand_accel(), peak_alt - 1));
        send_sample(mk(now_ms, rand_accel(), rand_accel(), rand_accel(), peak_alt - 2));
        now_ms += 1;
        send_sample(mk(now_ms, rand_accel(), rand_accel(), rand_accel(), peak_alt - 3));
    endtask

    // final phase: anything goes, only the peak may move
    task automatic test_apogee_noise();
        load_config('0, '0, '0, '0);
        send_sample(mk($urandom, rand_accel(), rand_accel(), rand_accel(), 32'sh7FFF_FFFF));
        for (int sub = 0; sub < 2; sub++) begin
            if (sub != 0)
                load_config(pick_thr(), pick_hold(), pick_hold(), pick_hold());
            repeat (50)
                send_sample(mk($urandom, AccelW'($urandom), AccelW'($urandom), AccelW'($urandom),
                               AltW'($urandom)));
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_wdata   <= '0;
        i_in_valid    <= 1'b0;
        i_sample_time <= '0;
        i_accel_x     <= '0;
        i_accel_y     <= '0;
        i_accel_z     <= '0;
        i_altitude_cm <= '0;
        cfg_shadow = '0;
        fl_phase   = PH_WAIT;
        watch_on   = 1'b0;
        watch_t0   = '0;
        peak_alt   = 32'sh8000_0000;
        launch_t   = '0;
        now_ms     = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_ground_extremes();
        test_ground_noise();
        test_liftoff();
        test_boost_noise();
        test_coast_entry();
        test_coast_noise();
        test_apogee_entry();
        test_apogee_noise();

        drain_results();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/fpd_pkg.sv
rtl/fpd_mag.sv
rtl/fpd_phase.sv
rtl/flight_phase_detector_top.sv
bench/tb_top.sv
